// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and defaults for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned VALUE_BITS_DEF = 32;
	localparam int unsigned PRIO_BITS_DEF  = 16;

	localparam int unsigned VALUE_PORT_W = 32;
	localparam int unsigned PRIO_PORT_W  = 16;
	localparam int unsigned COUNT_PORT_W = 5;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_CLR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle chain control, same for every cell
	typedef struct packed {
		logic shift_in;   // insert new entry at its sorted place
		logic shift_out;  // pop head, everything moves one toward head
	} cell_ctrl_t;

endpackage

// ===== rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted register chain; highest priority at the head, FIFO among equals.
// ----------------------------------------------------------------------------
// Result: the done strobe rises in the cycle after the command is taken.
// Throughput: one command per cycle; every cell compares with the new item
//   in parallel, so busy never rises.
// Reset: arst_n clears the count and the result strobe; slot contents are
//   left as they are. The receiver cannot stall; done lasts one cycle.
module stable_priority_queue #(
	parameter int unsigned CAPACITY   = spq_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_BITS = spq_pkg::VALUE_BITS_DEF,
	parameter int unsigned PRIO_BITS  = spq_pkg::PRIO_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        cmd,
	input  logic [spq_pkg::VALUE_PORT_W-1:0]  value,
	input  logic signed [spq_pkg::PRIO_PORT_W-1:0] priority_req,
	output logic                              done,
	output logic [spq_pkg::VALUE_PORT_W-1:0]  out_value,
	output logic                              out_valid,
	output logic [1:0]                        status,
	output logic [spq_pkg::COUNT_PORT_W-1:0]  entry_count,
	output logic                              is_empty
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	cmd_t                         cmd_c;
	logic                         accept;
	logic                         full;
	logic                         empty;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_nxt;
	cell_ctrl_t                   ctrl;
	logic [VALUE_BITS-1:0]        new_value;
	logic signed [PRIO_BITS-1:0]  new_prio;

	logic [CAPACITY-1:0]          occ;
	logic [CAPACITY-1:0]          keep;
	logic [VALUE_BITS-1:0]        cell_value [CAPACITY];
	logic signed [PRIO_BITS-1:0]  cell_prio  [CAPACITY];

	logic [VALUE_PORT_W-1:0]      res_value;
	logic                         res_valid;
	status_t                      res_status;

	logic                         done_q;
	logic [VALUE_PORT_W-1:0]      out_value_q;
	logic                         out_valid_q;
	status_t                      status_q;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign cmd_c     = cmd_t'(cmd);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign new_value = VALUE_BITS'(value);
	assign new_prio  = PRIO_BITS'(priority_req);

	assign ctrl.shift_in  = accept && (cmd_c == CMD_ENQ) && !full;
	assign ctrl.shift_out = accept && (cmd_c == CMD_DEQ) && !empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);

		spq_cell #(
			.VALUE_BITS (VALUE_BITS),
			.PRIO_BITS  (PRIO_BITS)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ[i]),
			.new_value   (new_value),
			.new_prio    (new_prio),
			.left_keep   ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1]),
			.left_value  (cell_value[(i == 0) ? 0 : i-1]),
			.left_prio   (cell_prio[(i == 0) ? 0 : i-1]),
			.right_value ((i == CAPACITY-1) ? '0 : cell_value[(i == CAPACITY-1) ? i : i+1]),
			.right_prio  ((i == CAPACITY-1) ? '0 : cell_prio[(i == CAPACITY-1) ? i : i+1]),
			.keep        (keep[i]),
			.value_q     (cell_value[i]),
			.prio_q      (cell_prio[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (accept) begin
			unique case (cmd_c)
				CMD_ENQ:  if (!full)  count_nxt = count_q + 1'b1;
				CMD_DEQ:  if (!empty) count_nxt = count_q - 1'b1;
				CMD_PEEK: count_nxt = count_q;
				CMD_CLR:  count_nxt = '0;
				default:  count_nxt = count_q;
			endcase
		end
	end

	always_comb begin
		res_value  = '0;
		res_valid  = 1'b0;
		res_status = ST_OK;
		unique case (cmd_c)
			CMD_ENQ: begin
				if (full) res_status = ST_FULL;
			end
			CMD_DEQ, CMD_PEEK: begin
				if (empty) begin
					res_status = ST_EMPTY;
				end else begin
					res_value = VALUE_PORT_W'(cell_value[0]);
					res_valid = 1'b1;
				end
			end
			CMD_CLR: res_status = ST_OK;
			default: res_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q <= res_value;
			out_valid_q <= res_valid;
			status_q    <= res_status;
		end
	end

	assign done        = done_q;
	assign out_value   = out_value_q;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = COUNT_PORT_W'(count_q);
	assign is_empty    = empty;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("command taken without a result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count beyond capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_c == CMD_CLR) |=> (is_empty && count_q == '0))
		else $error("clear left entries");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid) |-> (status_q == ST_OK && $past(!empty)))
		else $error("valid result from empty queue");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_c == CMD_ENQ && full) |=> $stable(count_q))
		else $error("enqueue when full changed count");

endmodule

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, decides locally whether to
// keep it, take the new item, take the left neighbor's or the right's.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int unsigned VALUE_BITS = spq_pkg::VALUE_BITS_DEF,
	parameter int unsigned PRIO_BITS  = spq_pkg::PRIO_BITS_DEF
) (
	input  logic                         clk,
	input  spq_pkg::cell_ctrl_t          ctrl,
	input  logic                         occ,
	input  logic [VALUE_BITS-1:0]        new_value,
	input  logic signed [PRIO_BITS-1:0]  new_prio,
	input  logic                         left_keep,
	input  logic [VALUE_BITS-1:0]        left_value,
	input  logic signed [PRIO_BITS-1:0]  left_prio,
	input  logic [VALUE_BITS-1:0]        right_value,
	input  logic signed [PRIO_BITS-1:0]  right_prio,
	output logic                         keep,
	output logic [VALUE_BITS-1:0]        value_q,
	output logic signed [PRIO_BITS-1:0]  prio_q
);
	import spq_pkg::*;

	// entry stays ahead of new item when its priority is >= the new one
	assign keep = occ && (prio_q >= new_prio);

	always_ff @(posedge clk) begin
		if (ctrl.shift_in) begin
			if (!keep) begin
				if (left_keep) begin
					value_q <= new_value;
					prio_q  <= new_prio;
				end else begin
					value_q <= left_value;
					prio_q  <= left_prio;
				end
			end
		end else if (ctrl.shift_out) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule
